[sv/psg_pkg.sv]
// Shared types, register codes and constant tables for the sound generator.
package psg_pkg;

    // Item kinds carried on the input side
    localparam logic [1:0] OP_SELECT = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOUND_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_CHIP_TYPE     = 2'd1;
    localparam logic [1:0] CFG_STEREO_MODE   = 2'd2;
    localparam logic [1:0] CFG_MASTER_VOLUME = 2'd3;

    // Chip register numbers
    localparam logic [3:0] REG_NOISE      = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_VOL_A      = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_SHAPE      = 4'd13;

    // Envelope direction codes
    localparam logic [1:0] ENV_HOLD = 2'd0;
    localparam logic [1:0] ENV_UP   = 2'd1;
    localparam logic [1:0] ENV_DOWN = 2'd2;

    // End-of-cycle behavior per shape, one bit per shape number
    localparam logic [15:0] SHAPES_HOLD_LOW = 16'h82FF;
    localparam logic [15:0] SHAPES_WRAP     = 16'h1100;
    localparam logic [15:0] SHAPES_ALT      = 16'h4400;

    // Level scaling: 65535 * 300
    localparam logic [24:0] LVL_DIV = 25'd19660500;

    // Reciprocal of the level scale, floor(2^39 / LVL_DIV)
    localparam logic [14:0] LVL_RECIP = 15'd27962;

    localparam logic [7:0] REG_MASK [16] = '{
        8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'hFF,
        8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF
    };

    // Volume curves: AY in the first half, YM in the second
    localparam logic [15:0] CURVE [64] = '{
        16'h0000, 16'h0000, 16'h0340, 16'h0340, 16'h04C0, 16'h04C0, 16'h06F2, 16'h06F2,
        16'h0A44, 16'h0A44, 16'h0F13, 16'h0F13, 16'h1510, 16'h1510, 16'h227E, 16'h227E,
        16'h289F, 16'h289F, 16'h414E, 16'h414E, 16'h5B21, 16'h5B21, 16'h7258, 16'h7258,
        16'h905E, 16'h905E, 16'hB550, 16'hB550, 16'hD7A0, 16'hD7A0, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000, 16'h00EF, 16'h01D0, 16'h0290, 16'h032A, 16'h03EE, 16'h04D2,
        16'h0611, 16'h0782, 16'h0912, 16'h0A36, 16'h0C31, 16'h0EB6, 16'h1130, 16'h13A0,
        16'h1751, 16'h1BF5, 16'h20E2, 16'h2594, 16'h2CA1, 16'h357F, 16'h3E45, 16'h475E,
        16'h5502, 16'h6620, 16'h7730, 16'h8844, 16'hA1D2, 16'hC102, 16'hE0A2, 16'hFFFF
    };

    // Panning weights, six columns per stereo mode
    localparam logic [6:0] PAN [42] = '{
        7'd58,  7'd58,  7'd58,  7'd58,  7'd58,  7'd58,
        7'd100, 7'd10,  7'd66,  7'd66,  7'd10,  7'd100,
        7'd100, 7'd10,  7'd10,  7'd100, 7'd66,  7'd66,
        7'd66,  7'd66,  7'd100, 7'd10,  7'd10,  7'd100,
        7'd10,  7'd100, 7'd100, 7'd10,  7'd66,  7'd66,
        7'd66,  7'd66,  7'd10,  7'd100, 7'd100, 7'd10,
        7'd10,  7'd100, 7'd66,  7'd66,  7'd100, 7'd10
    };

    // Settings the level table is built from
    typedef struct packed {
        logic       chip;
        logic [2:0] mode;
        logic [4:0] master;
    } psg_tab_cfg_t;

    // Level table read request: one level index per channel
    typedef struct packed {
        logic           en;
        logic [2:0][4:0] idx;
    } psg_rd_t;

endpackage

[sv/psg_lvl_tab.sv]
// Level table: sequential builder with reciprocal divide and six column memories.
module psg_lvl_tab (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psg_pkg::psg_tab_cfg_t cfg,
    input  logic                 start,
    input  psg_pkg::psg_rd_t     rd,
    output logic                 busy,
    output logic [14:0]          rd_data [6]
);
    import psg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_VOL   = 7'b0000010,
        ST_PAN   = 7'b0000100,
        ST_CURVE = 7'b0001000,
        ST_EST   = 7'b0010000,
        ST_REM   = 7'b0100000,
        ST_WRITE = 7'b1000000
    } bld_state_t;

    bld_state_t  state_reg, state_next;
    logic [2:0]  col_reg, col_next;
    logic [4:0]  lvl_reg, lvl_next;
    logic [16:0] vol_reg, vol_next;
    logic [22:0] vp_reg, vp_next;
    logic [38:0] prod_reg, prod_next;
    logic [38:0] back_prod;
    logic [25:0] rem_reg, rem_next;
    logic [14:0] q_reg, q_next;
    logic [14:0] q_fix;
    logic [2:0]  mode_eff;
    logic [5:0]  pan_idx;

    // Stereo mode 7 falls back to mono
    assign mode_eff = (cfg.mode == 3'd7) ? 3'd0 : cfg.mode;
    assign pan_idx  = {1'b0, mode_eff, 2'b00} + {2'b00, mode_eff, 1'b0} + {3'b000, col_reg};
    assign busy     = (state_reg != ST_IDLE);

    // Remainder of the estimate; one more step when it reaches the divisor
    assign back_prod = 39'(q_reg) * 39'(LVL_DIV);
    assign q_fix     = q_reg + 15'(rem_reg >= {1'b0, LVL_DIV});

    // Build sequencer: a volume step, then one entry per pass of pan, curve, estimate, remainder and write
    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        lvl_next   = lvl_reg;
        vol_next   = vol_reg;
        vp_next    = vp_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        case (state_reg)
            ST_VOL: begin
                vol_next   = {12'd0, cfg.master} * 17'd2184 + 17'd7;
                state_next = ST_PAN;
            end
            ST_PAN: begin
                vp_next    = 23'(vol_reg) * 23'(PAN[pan_idx]);
                state_next = ST_CURVE;
            end
            ST_CURVE: begin
                prod_next  = 39'(vp_reg) * 39'(CURVE[{cfg.chip, lvl_reg}]);
                state_next = ST_EST;
            end
            ST_EST: begin
                // Quotient estimate from the top bits, low by at most one
                q_next     = 15'((40'(prod_reg[38:14]) * 40'(LVL_RECIP)) >> 25);
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = 26'(prod_reg - back_prod);
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_PAN;
                if (lvl_reg == 5'd31) begin
                    lvl_next = '0;
                    if (col_reg == 3'd5) begin
                        state_next = ST_IDLE;
                    end else begin
                        col_next = col_reg + 3'd1;
                    end
                end else begin
                    lvl_next = lvl_reg + 5'd1;
                end
            end
            default: ;
        endcase
        // Any settings change restarts the whole build
        if (start) begin
            state_next = ST_VOL;
            col_next   = '0;
            lvl_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_VOL;
            col_reg   <= '0;
            lvl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            lvl_reg   <= lvl_next;
        end
        vol_reg  <= vol_next;
        vp_reg   <= vp_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    // One memory per column; columns 2i and 2i+1 belong to channel i
    for (genvar g = 0; g < 6; g++) begin : g_col
        logic [14:0] mem [32];
        logic [14:0] rdat_reg;

        always_ff @(posedge aclk) begin
            if (state_reg == ST_WRITE && col_reg == 3'(g)) begin
                mem[lvl_reg] <= q_fix;
            end
            if (rd.en) begin
                rdat_reg <= mem[rd.idx[g/2]];
            end
        end

        assign rd_data[g] = rdat_reg;
    end

endmodule

[sv/psg_tone_noise_envelope.sv]
// Top level of the three-channel tone, noise and envelope sound generator.
//
// Input channel (s_): one word per item. s_tuser holds the item kind
// (select register, write data, chip tick) and s_tdata the value byte.
// Only a tick produces an output word on the m_ channel: left level in
// m_tdata[15:0], right level in m_tdata[31:16].
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); the user
// must write it only while no items are in flight; the block does not enforce this.
// A tick passes stage A (chip state update), stage B (level table read) and
// stage C (sum and saturate) before its output word shows on m_tdata.
// Throughput: one item per cycle while no table rebuild runs and the receiver
// keeps up; stage A updates the tone, noise and envelope counters per item.
// Reset and every configuration write start a rebuild of the 192-entry level
// table: a volume step, then for each entry the pan and curve products, the
// reciprocal estimate, the remainder and the write; s_tready stays low
// meanwhile.
// When the receiver stalls, the output word is held and up to two more
// ticks are absorbed by the internal stages before s_tready drops.
module psg_tone_noise_envelope (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] value
    input  logic [1:0]  s_tuser,    // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] left_level, [31:16] right_level
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import psg_pkg::*;

    // Configuration
    logic         snd_en_reg;
    psg_tab_cfg_t tab_cfg_reg;

    // Pipeline stages
    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    logic [1:0]  a_op_reg;
    logic [7:0]  a_val_reg;
    logic [15:0] c_left_reg, c_right_reg;
    logic        ready_a, ready_b, ready_c, fire_a, tab_busy;

    // Chip state
    logic [7:0]  sreg_reg [16];
    logic [7:0]  sreg_next [16];
    logic [3:0]  sel_reg, sel_next;
    logic [11:0] tone_cnt_reg [3];
    logic [11:0] tone_cnt_next [3];
    logic [2:0]  tone_out_reg, tone_out_next;
    logic [5:0]  noise_cnt_reg, noise_cnt_next;
    logic [16:0] noise_sh_reg, noise_sh_next;
    logic        noise_out_reg, noise_out_next;
    logic [15:0] env_cnt_reg, env_cnt_next;
    logic [4:0]  env_step_reg, env_step_next;
    logic [1:0]  env_dir_reg, env_dir_next;

    psg_rd_t     rd;
    logic [14:0] rd_data [6];
    logic [16:0] sum_left, sum_right;

    // Stage handshakes
    assign ready_c  = !c_valid_reg || m_tready;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign fire_a   = a_valid_reg && ready_b;
    assign s_tready = ready_a && !tab_busy;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snd_en_reg         <= 1'b1;
            tab_cfg_reg.chip   <= 1'b0;
            tab_cfg_reg.mode   <= 3'd0;
            tab_cfg_reg.master <= 5'd15;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SOUND_ENABLE:  snd_en_reg         <= cfg_data[0];
                CFG_CHIP_TYPE:     tab_cfg_reg.chip   <= cfg_data[0];
                CFG_STEREO_MODE:   tab_cfg_reg.mode   <= cfg_data[2:0];
                CFG_MASTER_VOLUME: tab_cfg_reg.master <= cfg_data;
                default: ;
            endcase
        end
    end

    // Chip state update for the word in stage A
    always_comb begin
        logic [7:0]  wdata;
        logic [11:0] tone_per, tcnt_inc;
        logic [5:0]  ncnt_inc;
        logic [15:0] env_per, ecnt_inc, shape_bit;
        logic [6:0]  env_e;

        sreg_next      = sreg_reg;
        sel_next       = sel_reg;
        tone_cnt_next  = tone_cnt_reg;
        tone_out_next  = tone_out_reg;
        noise_cnt_next = noise_cnt_reg;
        noise_sh_next  = noise_sh_reg;
        noise_out_next = noise_out_reg;
        env_cnt_next   = env_cnt_reg;
        env_step_next  = env_step_reg;
        env_dir_next   = env_dir_reg;
        wdata          = a_val_reg & REG_MASK[sel_reg];
        tone_per       = '0;
        tcnt_inc       = '0;
        ncnt_inc       = noise_cnt_reg + 6'd1;
        env_per        = {sreg_reg[REG_ENV_COARSE], sreg_reg[REG_ENV_FINE]};
        ecnt_inc       = env_cnt_reg + 16'd1;
        shape_bit      = 16'd1 << sreg_reg[REG_SHAPE][3:0];
        env_e          = {2'b00, env_step_reg};

        if (fire_a) begin
            case (a_op_reg)
                OP_SELECT: begin
                    sel_next = a_val_reg[3:0];
                end
                OP_WRITE: begin
                    if (snd_en_reg) begin
                        sreg_next[sel_reg] = wdata;
                        // Shape write restarts the envelope
                        if (sel_reg == REG_SHAPE) begin
                            env_cnt_next = '0;
                            if (wdata[2]) begin
                                env_step_next = 5'd0;
                                env_dir_next  = ENV_UP;
                            end else begin
                                env_step_next = 5'd31;
                                env_dir_next  = ENV_DOWN;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    // Tone dividers
                    for (int i = 0; i < 3; i++) begin
                        tone_per = {sreg_reg[4'(2*i+1)][3:0], sreg_reg[4'(2*i)]};
                        tcnt_inc = tone_cnt_reg[i] + 12'd1;
                        if (tcnt_inc >= tone_per) begin
                            tone_cnt_next[i] = '0;
                            tone_out_next[i] = ~tone_out_reg[i];
                        end else begin
                            tone_cnt_next[i] = tcnt_inc;
                        end
                    end
                    // Noise divider and shift register
                    if (ncnt_inc >= {sreg_reg[REG_NOISE][4:0], 1'b0}) begin
                        noise_cnt_next = '0;
                        noise_sh_next  = {noise_sh_reg[15:0], 1'b1}
                                       ^ {16'd0, noise_sh_reg[16] ^ noise_sh_reg[13]};
                        noise_out_next = noise_sh_next[16];
                    end else begin
                        noise_cnt_next = ncnt_inc;
                    end
                    // Envelope divider and step
                    if (ecnt_inc >= env_per) begin
                        env_cnt_next = '0;
                        case (env_dir_reg)
                            ENV_HOLD: env_e = {2'b00, env_step_reg};
                            ENV_UP:   env_e = {2'b00, env_step_reg} + 7'd1;
                            default:  env_e = {2'b00, env_step_reg} - 7'd1;
                        endcase
                        env_step_next = env_e[4:0];
                        // Out of range: negative or above 31
                        if (env_e[6] || env_e[5]) begin
                            if (|(shape_bit & SHAPES_HOLD_LOW)) begin
                                env_step_next = 5'd0;
                                env_dir_next  = ENV_HOLD;
                            end else if (|(shape_bit & SHAPES_WRAP)) begin
                                env_step_next = env_e[6] ? 5'd31 : 5'd0;
                            end else if (|(shape_bit & SHAPES_ALT)) begin
                                if (env_e[6]) begin
                                    env_step_next = 5'd0;
                                    env_dir_next  = ENV_UP;
                                end else begin
                                    env_step_next = 5'd31;
                                    env_dir_next  = ENV_DOWN;
                                end
                            end else begin
                                env_step_next = 5'd31;
                                env_dir_next  = ENV_HOLD;
                            end
                        end
                    end else begin
                        env_cnt_next = ecnt_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Level index per channel from the updated generators
    always_comb begin
        logic [7:0] vr;
        logic [4:0] lvl;
        logic       t, n;

        rd.en = fire_a && (a_op_reg == OP_TICK);
        vr    = '0;
        lvl   = '0;
        t     = 1'b0;
        n     = 1'b0;
        for (int i = 0; i < 3; i++) begin
            vr  = sreg_reg[REG_VOL_A + 4'(i)];
            lvl = vr[4] ? env_step_next : {vr[3:0], 1'b1};
            t   = tone_out_next[i] || sreg_reg[REG_MIXER][i];
            n   = noise_out_next || sreg_reg[REG_MIXER][i+3];
            rd.idx[i] = (t && n) ? lvl : 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sreg_reg      <= '{default: '0};
            sel_reg       <= '0;
            tone_cnt_reg  <= '{default: '0};
            tone_out_reg  <= '0;
            noise_cnt_reg <= '0;
            noise_sh_reg  <= '0;
            noise_out_reg <= 1'b0;
            env_cnt_reg   <= '0;
            env_step_reg  <= '0;
            env_dir_reg   <= ENV_HOLD;
        end else begin
            sreg_reg      <= sreg_next;
            sel_reg       <= sel_next;
            tone_cnt_reg  <= tone_cnt_next;
            tone_out_reg  <= tone_out_next;
            noise_cnt_reg <= noise_cnt_next;
            noise_sh_reg  <= noise_sh_next;
            noise_out_reg <= noise_out_next;
            env_cnt_reg   <= env_cnt_next;
            env_step_reg  <= env_step_next;
            env_dir_reg   <= env_dir_next;
        end
    end

    psg_lvl_tab u_lvl_tab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (tab_cfg_reg),
        .start   (cfg_wr_en),
        .rd      (rd),
        .busy    (tab_busy),
        .rd_data (rd_data)
    );

    // Sum the three channels per side
    assign sum_left  = {2'b00, rd_data[0]} + {2'b00, rd_data[2]} + {2'b00, rd_data[4]};
    assign sum_right = {2'b00, rd_data[1]} + {2'b00, rd_data[3]} + {2'b00, rd_data[5]};

    // Advance the stage valids; hold while the next stage cannot take the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                a_valid_reg <= s_tvalid && s_tready;
            end
            if (ready_b) begin
                b_valid_reg <= rd.en;
            end
            if (ready_c) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_op_reg  <= s_tuser;
            a_val_reg <= s_tdata;
        end
        if (ready_c && b_valid_reg) begin
            c_left_reg  <= sum_left[16] ? 16'hFFFF : sum_left[15:0];
            c_right_reg <= sum_right[16] ? 16'hFFFF : sum_right[15:0];
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {c_right_reg, c_left_reg};

endmodule

[sv/psg_chk.sv]
// Port-level checks for the sound generator, bound to the top level.
module psg_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_wr_en
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // A settings write starts a table rebuild that blocks input
    a_cfg_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken right after a settings write");

    // Reset empties the pipeline and starts the rebuild
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block not quiet after reset");

    // Keep a stalled output word while an input word is taken
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped under stall");

endmodule

bind psg_tone_noise_envelope psg_chk u_psg_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en)
);

[bench/psg_tone_noise_envelope_test.sv]
// Self-checking bench for the sound generator: predicts every tick's level word and compares.
module psg_tone_noise_envelope_test;
    import psg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } level_pair_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
    } psg_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;

    psg_tone_noise_envelope u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Words waiting to go out, levels waiting to come back
    psg_word_t   pending_words[$];
    level_pair_t expected_levels[$];
    int          words_outstanding = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // Shadow of the generator state
    logic        cfg_enable;
    logic        cfg_chip;
    logic [2:0]  cfg_mode;
    logic [4:0]  cfg_master;
    logic [7:0]  chip_regs [16];
    logic [3:0]  sel_reg;
    logic [11:0] tone_cnt [3];
    logic        tone_out [3];
    logic [5:0]  noise_cnt;
    logic [16:0] noise_lfsr;
    logic        noise_out;
    logic [15:0] env_cnt;
    logic [4:0]  env_step;
    logic [1:0]  env_dir;
    logic [15:0] level_tab [192];

    // Rebuild the per-column level table from the current settings
    function void build_level_tab();
        longint unsigned vol, prod;
        int mode;
        vol = longint'(cfg_master) * 2184 + 7;
        mode = (cfg_mode > 6) ? 0 : int'(cfg_mode);
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 32; i++) begin
                prod = vol * longint'(CURVE[int'(cfg_chip) * 32 + i]) * longint'(PAN[mode * 6 + j]);
                level_tab[j * 32 + i] = 16'(prod / longint'(LVL_DIV));
            end
        end
    endfunction

    // Advance dividers, noise and envelope by one tick, then queue the mixed levels
    function void chip_tick();
        int unsigned period, lvl, idx, left, right;
        int e;
        logic [15:0] shape_bits;
        logic [7:0] vr;
        logic [7:0] mixer;
        logic tone_on, noise_on, fb;
        level_pair_t res;
        left = 0;
        right = 0;
        mixer = chip_regs[REG_MIXER];
        for (int i = 0; i < 3; i++) begin
            period = 32'({chip_regs[2 * i + 1], chip_regs[2 * i]});
            tone_cnt[i] = tone_cnt[i] + 12'd1;
            if (tone_cnt[i] >= period) begin
                tone_cnt[i] = '0;
                tone_out[i] = ~tone_out[i];
            end
        end
        // Noise divider and shift register
        noise_cnt = noise_cnt + 6'd1;
        if (noise_cnt >= int'(chip_regs[REG_NOISE]) * 2) begin
            fb = noise_lfsr[16] ^ noise_lfsr[13];
            noise_cnt = '0;
            noise_lfsr = {noise_lfsr[15:0], 1'b1} ^ {16'd0, fb};
            noise_out = noise_lfsr[16];
        end
        // Envelope divider and step with end-of-cycle rules
        period = 32'({chip_regs[REG_ENV_COARSE], chip_regs[REG_ENV_FINE]});
        env_cnt = env_cnt + 16'd1;
        if (env_cnt >= period) begin
            e = int'(env_step);
            env_cnt = '0;
            if (env_dir == ENV_UP) e++;
            else if (env_dir >= ENV_DOWN) e--;
            if (e < 0 || e > 31) begin
                shape_bits = 16'd1 << chip_regs[REG_SHAPE][3:0];
                if ((shape_bits & SHAPES_HOLD_LOW) != 0) begin
                    e = 0;
                    env_dir = ENV_HOLD;
                end else if ((shape_bits & SHAPES_WRAP) != 0) begin
                    e = (e < 0) ? 31 : 0;
                end else if ((shape_bits & SHAPES_ALT) != 0) begin
                    if (e < 0) begin
                        e = 0;
                        env_dir = ENV_UP;
                    end else begin
                        e = 31;
                        env_dir = ENV_DOWN;
                    end
                end else begin
                    e = 31;
                    env_dir = ENV_HOLD;
                end
            end
            env_step = 5'(e);
        end
        // Mix the three channels
        for (int i = 0; i < 3; i++) begin
            vr = chip_regs[int'(REG_VOL_A) + i];
            lvl = vr[4] ? int'(env_step) : ((int'(vr[3:0]) * 2 + 1) & 31);
            tone_on = tone_out[i] | mixer[i];
            noise_on = noise_out | mixer[i + 3];
            idx = (tone_on && noise_on) ? lvl : 0;
            left += level_tab[i * 64 + idx];
            right += level_tab[i * 64 + 32 + idx];
        end
        res.left = (left > 32'hFFFF) ? 16'hFFFF : left[15:0];
        res.right = (right > 32'hFFFF) ? 16'hFFFF : right[15:0];
        expected_levels.push_back(res);
    endfunction

    // Apply one accepted word to the shadow state
    function void apply_word(logic [1:0] op, logic [7:0] value);
        case (op)
            OP_SELECT: sel_reg = value[3:0];
            OP_WRITE: begin
                if (cfg_enable) begin
                    chip_regs[sel_reg] = value & REG_MASK[sel_reg];
                    if (sel_reg == REG_SHAPE) begin
                        env_cnt = '0;
                        if (chip_regs[REG_SHAPE][2]) begin
                            env_step = 5'd0;
                            env_dir = ENV_UP;
                        end else begin
                            env_step = 5'd31;
                            env_dir = ENV_DOWN;
                        end
                    end
                end
            end
            OP_TICK: chip_tick();
            default: ;
        endcase
    endfunction

    function void flag_mismatch(string msg);
        if (mismatches < 10) $display("MISMATCH: %s", msg);
        mismatches++;
    endfunction

    task automatic queue_word(logic [1:0] op, logic [7:0] value);
        psg_word_t w;
        w.op = op;
        w.value = value;
        words_outstanding++;
        pending_words.push_back(w);
    endtask

    // Select a chip register, with random upper bits, then write it
    task automatic queue_write(logic [3:0] reg_num, logic [7:0] value);
        logic [3:0] hi;
        hi = 4'($urandom);
        queue_word(OP_SELECT, {hi, reg_num});
        queue_word(OP_WRITE, value);
    endtask

    // Mostly register writes and tick runs, some loose words
    task automatic queue_random(int n);
        int produced, r, kind, run;
        logic [7:0] v;
        produced = 0;
        while (produced < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                r = $urandom_range(0, 15);
                // Keep envelope restarts rare so it reaches its ends
                if (r == REG_SHAPE && $urandom_range(0, 2) != 0) r = REG_MIXER;
                v = 8'($urandom_range(0, 255));
                if ((r <= REG_NOISE || r == REG_ENV_FINE || r == REG_ENV_COARSE) &&
                    $urandom_range(0, 3) != 0)
                    v = 8'($urandom_range(0, 3));
                queue_write(4'(r), v);
                produced += 2;
            end else if (kind < 9) begin
                run = $urandom_range(1, 24);
                repeat (run) queue_word(OP_TICK, 8'($urandom));
                produced += run;
            end else begin
                queue_word(2'($urandom_range(0, 3)), 8'($urandom));
                produced++;
            end
        end
    endtask

    // Hold until every word is taken and every level word is back
    task automatic wait_idle();
        while (words_outstanding != 0 || expected_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SOUND_ENABLE:  cfg_enable = data[0];
            CFG_CHIP_TYPE:     cfg_chip = data[0];
            CFG_STEREO_MODE:   cfg_mode = data[2:0];
            CFG_MASTER_VOLUME: cfg_master = data;
            default: ;
        endcase
        build_level_tab();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // Let the table rebuild start, then wait for it to finish
        repeat (3) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic apply_settings(logic en, logic chip, logic [2:0] mode, logic [4:0] master);
        logic [3:0] junk;
        wait_idle();
        junk = 4'($urandom);
        write_cfg(CFG_SOUND_ENABLE, {junk, en});
        junk = 4'($urandom);
        write_cfg(CFG_CHIP_TYPE, {junk, chip});
        junk = 4'($urandom);
        write_cfg(CFG_STEREO_MODE, {junk[1:0], mode});
        write_cfg(CFG_MASTER_VOLUME, master);
    endtask

    // Driver: bursts of words with random gaps
    psg_word_t next_word;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0 || pending_words.size() == 0) begin
                if (gap_left != 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_word.op;
                s_tdata <= next_word.value;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Monitor: stall pattern, level check, prediction on accept
    level_pair_t got_levels, want_levels;
    int stall_mode = 0;
    logic [5:0] stall_phase = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_levels = m_tdata;
                if (expected_levels.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word left=%0d right=%0d",
                                            got_levels.left, got_levels.right));
                end else begin
                    want_levels = expected_levels.pop_front();
                    if (got_levels.left !== want_levels.left)
                        flag_mismatch($sformatf("left expected %0d got %0d",
                                                want_levels.left, got_levels.left));
                    if (got_levels.right !== want_levels.right)
                        flag_mismatch($sformatf("right expected %0d got %0d",
                                                want_levels.right, got_levels.right));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_word(s_tuser, s_tdata);
                words_outstanding--;
            end
            stall_phase = stall_phase + 6'd1;
            if (stall_phase == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (stall_phase[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // Reset values of the shadow state
        cfg_enable = 1'b1;
        cfg_chip = 1'b0;
        cfg_mode = 3'd0;
        cfg_master = 5'd15;
        for (int i = 0; i < 16; i++) chip_regs[i] = '0;
        for (int i = 0; i < 3; i++) begin
            tone_cnt[i] = '0;
            tone_out[i] = 1'b0;
        end
        sel_reg = '0;
        noise_cnt = '0;
        noise_lfsr = '0;
        noise_out = 1'b0;
        env_cnt = '0;
        env_step = '0;
        env_dir = ENV_HOLD;
        build_level_tab();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset state with zero periods, unknown kind, extremes
        queue_word(OP_TICK, 8'h00);
        queue_word(2'd3, 8'hFF);
        queue_write(REG_VOL_A, 8'hFF);
        queue_write(4'd9, 8'h0F);
        queue_write(REG_SHAPE, 8'hFF);
        queue_word(OP_TICK, 8'hFF);
        // Same shape again still restarts the envelope
        queue_write(REG_SHAPE, 8'h0F);
        queue_word(OP_TICK, 8'h00);
        queue_write(4'd14, 8'hFF);
        queue_write(4'd15, 8'hA5);
        queue_write(4'd0, 8'hFF);
        queue_write(4'd1, 8'hFF);
        queue_word(OP_SELECT, 8'hF7);
        queue_word(OP_WRITE, 8'h00);
        queue_word(OP_TICK, 8'h55);
        queue_word(OP_TICK, 8'hAA);
        queue_word(OP_TICK, 8'h00);
        queue_random(180);

        // Walk the settings, every stereo mode and both ends of the volume
        apply_settings(1'b1, 1'b1, 3'd1, 5'd30);
        queue_random(190);
        apply_settings(1'b1, 1'b0, 3'd6, 5'd0);
        queue_random(190);
        apply_settings(1'b0, 1'b1, 3'd7, 5'd31);
        queue_random(190);
        apply_settings(1'b1, 1'b0, 3'd2, 5'd31);
        queue_random(190);
        apply_settings(1'b1, 1'b1, 3'd3, 5'd7);
        queue_random(190);
        apply_settings(1'b1, 1'b0, 3'd4, 5'd20);
        queue_random(190);
        apply_settings(1'b1, 1'b1, 3'd5, 5'd1);
        queue_random(190);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
sv/psg_pkg.sv
sv/psg_lvl_tab.sv
sv/psg_tone_noise_envelope.sv
sv/psg_chk.sv
bench/psg_tone_noise_envelope_test.sv
